[hw/rtl/sfcm_pkg.sv]
package sfcm_pkg;

  localparam int ADDR_BITS_DEF = 24;
  localparam int ADDR_W        = 24;
  localparam int OP_W          = 8;
  localparam int DATA_W        = 8;
  localparam int KIND_W        = 3;
  localparam int STEP_W        = 7;
  localparam int CFG_IDX_W     = 2;
  localparam int IN_TDATA_W    = 48;
  localparam int OUT_TDATA_W   = 16;

  // Input kind codes
  localparam logic [KIND_W-1:0] KIND_TICK   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_WREN   = 3'd1;
  localparam logic [KIND_W-1:0] KIND_ERASE  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_PROG   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_READ   = 3'd4;
  localparam logic [KIND_W-1:0] KIND_STATUS = 3'd5;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_WREN_OP   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ERASE_OP  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STATUS_OP = 2'd2;

  localparam logic [OP_W-1:0] WREN_OP_RST   = 8'h06;
  localparam logic [OP_W-1:0] ERASE_OP_RST  = 8'h60;
  localparam logic [OP_W-1:0] STATUS_OP_RST = 8'h05;

  typedef enum logic [2:0] {
    ITEM_TICK,
    ITEM_WREN,
    ITEM_ERASE,
    ITEM_PROG,
    ITEM_READ,
    ITEM_STATUS,
    ITEM_NOP
  } item_t;

  typedef enum logic [2:0] {
    CMD_IDLE,
    CMD_WREN,
    CMD_ERASE,
    CMD_PROG,
    CMD_READ,
    CMD_STATUS
  } cmd_t;

  typedef struct packed {
    item_t              item;
    logic [OP_W-1:0]    opcode;
    logic [ADDR_W-1:0]  address;
    logic [DATA_W-1:0]  write_data;
    logic               miso;
  } q_entry_t;

  typedef struct packed {
    logic [OP_W-1:0] wren_op;
    logic [OP_W-1:0] erase_op;
    logic [OP_W-1:0] status_op;
  } cfg_regs_t;

endpackage

[hw/rtl/sfcm_front.sv]
module sfcm_front (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  input  logic [sfcm_pkg::IN_TDATA_W-1:0]       in_tdata,
  input  logic [sfcm_pkg::KIND_W-1:0]           in_tuser,
  output logic                                  q_valid,
  output sfcm_pkg::q_entry_t                    q_head,
  input  logic                                  q_pop
);

  localparam int QD = 2;

  sfcm_pkg::q_entry_t mem_r [QD];
  sfcm_pkg::q_entry_t entry;
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       push, pop;

  // Classify the kind code
  always_comb begin
    unique case (in_tuser)
      sfcm_pkg::KIND_TICK:   entry.item = sfcm_pkg::ITEM_TICK;
      sfcm_pkg::KIND_WREN:   entry.item = sfcm_pkg::ITEM_WREN;
      sfcm_pkg::KIND_ERASE:  entry.item = sfcm_pkg::ITEM_ERASE;
      sfcm_pkg::KIND_PROG:   entry.item = sfcm_pkg::ITEM_PROG;
      sfcm_pkg::KIND_READ:   entry.item = sfcm_pkg::ITEM_READ;
      sfcm_pkg::KIND_STATUS: entry.item = sfcm_pkg::ITEM_STATUS;
      default:               entry.item = sfcm_pkg::ITEM_NOP;
    endcase
    entry.opcode     = in_tdata[7:0];
    entry.address    = in_tdata[31:8];
    entry.write_data = in_tdata[39:32];
    entry.miso       = in_tdata[40];
  end

  assign in_tready = (count_r != 2'(QD));
  assign push      = in_tvalid && in_tready;
  assign q_valid   = (count_r != 2'd0);
  assign pop       = q_pop && q_valid;
  assign q_head    = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (pop && !push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= entry;
    end
  end

  a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
    push && !pop |=> count_r == $past(count_r) + 2'd1)
    else $error("queue count did not advance on push");

endmodule

[hw/rtl/sfcm_back.sv]
module sfcm_back #(
  parameter int ADDR_BITS = sfcm_pkg::ADDR_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  sfcm_pkg::cfg_regs_t                   cfg,
  input  logic                                  q_valid,
  input  sfcm_pkg::q_entry_t                    q_head,
  output logic                                  q_pop,
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  output logic [sfcm_pkg::OUT_TDATA_W-1:0]      out_tdata
);

  localparam int SEND_W = ADDR_BITS + 16;
  localparam int CNT_W  = $clog2(SEND_W + 1);
  localparam int SW     = sfcm_pkg::STEP_W;

  sfcm_pkg::cmd_t           active_r, active_nxt;
  logic [SW-1:0]            step_r, step_nxt;
  logic [SEND_W-1:0]        send_shift_r, send_shift_nxt;
  logic [CNT_W-1:0]         send_bits_r, send_bits_nxt;
  logic                     recv_en_r, recv_en_nxt;
  logic [7:0]               rx_r, rx_nxt;
  logic                     polling_r, polling_nxt;
  logic                     sel_pend_r, sel_pend_nxt;
  logic                     cs_r, cs_nxt;
  logic                     sck_r, sck_nxt;
  logic                     mosi_r, mosi_nxt;
  logic [7:0]               last_read_r, last_read_nxt;
  logic                     done_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic [sfcm_pkg::OUT_TDATA_W-1:0] out_data_r, out_data_nxt;
  logic                     take;
  logic [SW-1:0]            sendh, total;
  logic [ADDR_BITS-1:0]     addr_ext;
  logic [SEND_W-1:0]        word_wren, word_erase, word_status, word_prog, word_read;

  generate
    if (ADDR_BITS > sfcm_pkg::ADDR_W) begin : g_addr_wide
      assign addr_ext = {{(ADDR_BITS - sfcm_pkg::ADDR_W){1'b0}}, q_head.address};
    end else if (ADDR_BITS == sfcm_pkg::ADDR_W) begin : g_addr_eq
      assign addr_ext = q_head.address;
    end else begin : g_addr_narrow
      assign addr_ext = q_head.address[ADDR_BITS-1:0];
    end
  endgenerate

  // Left-align every outgoing word; mosi always comes from the top bit
  assign word_wren   = {cfg.wren_op, {(SEND_W - 8){1'b0}}};
  assign word_erase  = {cfg.erase_op, {(SEND_W - 8){1'b0}}};
  assign word_status = {cfg.status_op, {(SEND_W - 8){1'b0}}};
  assign word_prog   = {q_head.opcode, addr_ext, q_head.write_data};
  assign word_read   = {q_head.opcode, addr_ext, 8'h00};

  assign sendh = SW'(send_bits_r) << 1;
  assign total = sendh + (recv_en_r ? SW'(16) : SW'(0));

  assign take  = q_valid && (!out_valid_r || out_tready);
  assign q_pop = take;

  always_comb begin
    active_nxt     = active_r;
    step_nxt       = step_r;
    send_shift_nxt = send_shift_r;
    send_bits_nxt  = send_bits_r;
    recv_en_nxt    = recv_en_r;
    rx_nxt         = rx_r;
    polling_nxt    = polling_r;
    sel_pend_nxt   = sel_pend_r;
    cs_nxt         = cs_r;
    sck_nxt        = sck_r;
    mosi_nxt       = mosi_r;
    last_read_nxt  = last_read_r;
    done_nxt       = 1'b0;

    if (take) begin
      if (active_r == sfcm_pkg::CMD_IDLE) begin
        if (q_head.item != sfcm_pkg::ITEM_TICK && q_head.item != sfcm_pkg::ITEM_NOP) begin
          polling_nxt  = 1'b0;
          sel_pend_nxt = 1'b0;
          cs_nxt       = 1'b0;
          rx_nxt       = 8'h00;
          step_nxt     = '0;
          recv_en_nxt  = 1'b0;
          send_bits_nxt = CNT_W'(8);
        end
        unique case (q_head.item)
          sfcm_pkg::ITEM_WREN: begin
            active_nxt     = sfcm_pkg::CMD_WREN;
            send_shift_nxt = word_wren;
          end
          sfcm_pkg::ITEM_ERASE: begin
            active_nxt     = sfcm_pkg::CMD_ERASE;
            send_shift_nxt = word_erase;
          end
          sfcm_pkg::ITEM_PROG: begin
            active_nxt     = sfcm_pkg::CMD_PROG;
            send_shift_nxt = word_prog;
            send_bits_nxt  = CNT_W'(SEND_W);
          end
          sfcm_pkg::ITEM_READ: begin
            active_nxt     = sfcm_pkg::CMD_READ;
            send_shift_nxt = word_read;
            send_bits_nxt  = CNT_W'(SEND_W - 8);
            recv_en_nxt    = 1'b1;
          end
          sfcm_pkg::ITEM_STATUS: begin
            active_nxt     = sfcm_pkg::CMD_STATUS;
            send_shift_nxt = word_status;
            recv_en_nxt    = 1'b1;
          end
          default: begin
          end
        endcase
      end else if (q_head.item == sfcm_pkg::ITEM_TICK) begin
        if (sel_pend_r) begin
          sel_pend_nxt = 1'b0;
          cs_nxt       = 1'b0;
        end else if (step_r < sendh) begin
          if (!step_r[0]) begin
            sck_nxt        = 1'b0;
            mosi_nxt       = send_shift_r[SEND_W-1];
            send_shift_nxt = send_shift_r << 1;
          end else begin
            sck_nxt = 1'b1;
          end
          step_nxt = step_r + SW'(1);
        end else if (step_r < total) begin
          if (!step_r[0]) begin
            sck_nxt = 1'b1;
          end else begin
            sck_nxt = 1'b0;
            rx_nxt  = {rx_r[6:0], q_head.miso};
          end
          step_nxt = step_r + SW'(1);
        end else begin
          cs_nxt = 1'b1;
          if (active_r inside {sfcm_pkg::CMD_READ, sfcm_pkg::CMD_STATUS} && !polling_r) begin
            last_read_nxt = rx_r;
          end
          if ((polling_r && !rx_r[0]) ||
              (!polling_r && active_r == sfcm_pkg::CMD_STATUS)) begin
            polling_nxt = 1'b0;
            active_nxt  = sfcm_pkg::CMD_IDLE;
            done_nxt    = 1'b1;
          end else begin
            // Start another busy poll: select tick first, then status opcode
            polling_nxt    = 1'b1;
            sel_pend_nxt   = 1'b1;
            send_shift_nxt = word_status;
            send_bits_nxt  = CNT_W'(8);
            recv_en_nxt    = 1'b1;
            rx_nxt         = 8'h00;
            step_nxt       = '0;
          end
        end
      end
    end
  end

  always_comb begin
    out_valid_nxt = take ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);
    out_data_nxt  = out_data_r;
    if (take) begin
      out_data_nxt = {3'b000, done_nxt, last_read_nxt,
                      (active_nxt != sfcm_pkg::CMD_IDLE), mosi_nxt, sck_nxt, cs_nxt};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= sfcm_pkg::CMD_IDLE;
      step_r      <= '0;
      send_bits_r <= '0;
      recv_en_r   <= 1'b0;
      rx_r        <= 8'h00;
      polling_r   <= 1'b0;
      sel_pend_r  <= 1'b0;
      cs_r        <= 1'b1;
      sck_r       <= 1'b1;
      mosi_r      <= 1'b0;
      last_read_r <= 8'h00;
      out_valid_r <= 1'b0;
    end else begin
      active_r    <= active_nxt;
      step_r      <= step_nxt;
      send_bits_r <= send_bits_nxt;
      recv_en_r   <= recv_en_nxt;
      rx_r        <= rx_nxt;
      polling_r   <= polling_nxt;
      sel_pend_r  <= sel_pend_nxt;
      cs_r        <= cs_nxt;
      sck_r       <= sck_nxt;
      mosi_r      <= mosi_nxt;
      last_read_r <= last_read_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    send_shift_r <= send_shift_nxt;
    out_data_r   <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    take && done_nxt |=> active_r == sfcm_pkg::CMD_IDLE)
    else $error("command finished but sequencer not idle");

  a_idle_deselect: assert property (@(posedge clk) disable iff (!rst_n)
    active_r == sfcm_pkg::CMD_IDLE |-> cs_r)
    else $error("chip select low while idle");

  a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
    active_r != sfcm_pkg::CMD_IDLE |-> step_r <= total)
    else $error("half-bit step past end of transfer");

endmodule

[hw/rtl/spi_flash_command_master_top.sv]
// Channel | Signals                                   | Direction
// in      | in_tvalid, in_tready, in_tdata, in_tuser  | command or tick into the block
// out     | out_tvalid, out_tready, out_tdata         | pin levels and status per item
// cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data | opcode register writes
//
// One item per cycle sustained while out_tready is high; each item gives exactly one result.
// Path: the classify queue (two entries), then the sequencer's output register.
// Reset (rst_n low, synchronous) idles the sequencer with cs_n and sck high, mosi low.
// A stalled out_tready holds the result; the queue absorbs up to two more items.
module spi_flash_command_master_top #(
  parameter int ADDR_BITS = sfcm_pkg::ADDR_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  // opcode[7:0], address[31:8], write_data[39:32], miso[40], zero fill
  input  logic [sfcm_pkg::IN_TDATA_W-1:0]       in_tdata,
  // kind[2:0]
  input  logic [sfcm_pkg::KIND_W-1:0]           in_tuser,
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  // cs_n[0], sck[1], mosi[2], busy_res[3], read_data[11:4], done_res[12], zero fill
  output logic [sfcm_pkg::OUT_TDATA_W-1:0]      out_tdata,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [sfcm_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [sfcm_pkg::OP_W-1:0]             cfg_data
);

  sfcm_pkg::cfg_regs_t cfg_r, cfg_nxt;
  sfcm_pkg::q_entry_t  q_head;
  logic                q_valid;
  logic                q_pop;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        sfcm_pkg::CFG_WREN_OP:   cfg_nxt.wren_op   = cfg_data;
        sfcm_pkg::CFG_ERASE_OP:  cfg_nxt.erase_op  = cfg_data;
        sfcm_pkg::CFG_STATUS_OP: cfg_nxt.status_op = cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.wren_op   <= sfcm_pkg::WREN_OP_RST;
      cfg_r.erase_op  <= sfcm_pkg::ERASE_OP_RST;
      cfg_r.status_op <= sfcm_pkg::STATUS_OP_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  sfcm_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .q_pop     (q_pop)
  );

  sfcm_back #(
    .ADDR_BITS (ADDR_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .q_valid    (q_valid),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
